// ===== src/ddc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddc_pkg
// Shared types and constants of the sector DMA disk controller.
// ----------------------------------------------------------------------------
package ddc_pkg;

  localparam int SECTOR_BYTES = 512;

  localparam int DATA_W   = 64;
  localparam int CNT_W    = 32;
  localparam int SECT_W   = 31;
  localparam int CAP_W    = 31;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
  localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

  // control register bit positions; STRT reads as zero
  localparam int CTL_IEN  = 0;
  localparam int CTL_WRT  = 1;
  localparam int CTL_STRT = 2;
  localparam int CTL_BUSY = 3;
  localparam int CTL_ERR  = 4;

  // configuration register word index
  localparam logic [0:0] CFG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_WRITE     = 2'd1,
    OP_XFER_OK   = 2'd2,
    OP_XFER_FAIL = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_CONTROL  = 3'd0,
    REG_COUNT    = 3'd1,
    REG_SECTOR   = 3'd2,
    REG_DMA_ADDR = 3'd3,
    REG_CAPACITY = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    SEL_CONTROL,
    SEL_COUNT,
    SEL_SECTOR,
    SEL_ADDR,
    SEL_CAPACITY,
    SEL_NONE
  } reg_sel_t;

  typedef struct packed {
    op_t                 op;
    reg_sel_t            sel;
    logic [DATA_W-1:0]   data;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic                sector_request;
    logic                request_is_write;
    logic [SECT_W-1:0]   request_sector;
    logic [DATA_W-1:0]   request_address;
    logic                interrupt_pulse;
    logic                busy_res;
    logic                error;
  } res_t;

endpackage

// ===== src/ddc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddc_front
// Accepts input beats, decodes operation and register select, and holds the
// decoded commands in a short queue for the execution side.
// ----------------------------------------------------------------------------
module ddc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    in_operation,
  input  logic [2:0]                    in_reg_index,
  input  logic [ddc_pkg::DATA_W-1:0]    in_write_data,
  output logic                          cmd_valid,
  output ddc_pkg::cmd_t                 cmd,
  input  logic                          cmd_pop
);

  ddc_pkg::cmd_t                 cmdq_r [ddc_pkg::CMDQ_DEPTH];
  logic [ddc_pkg::CMDQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [ddc_pkg::CMDQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [ddc_pkg::CMDQ_CW-1:0]   cnt_r, cnt_nxt;
  ddc_pkg::cmd_t                 dec;
  logic                          push_ok;
  logic                          pop_ok;

  // classify the incoming beat
  always_comb begin
    dec.op   = ddc_pkg::op_t'(in_operation);
    dec.data = in_write_data;
    case (ddc_pkg::reg_idx_t'(in_reg_index))
      ddc_pkg::REG_CONTROL:  dec.sel = ddc_pkg::SEL_CONTROL;
      ddc_pkg::REG_COUNT:    dec.sel = ddc_pkg::SEL_COUNT;
      ddc_pkg::REG_SECTOR:   dec.sel = ddc_pkg::SEL_SECTOR;
      ddc_pkg::REG_DMA_ADDR: dec.sel = ddc_pkg::SEL_ADDR;
      ddc_pkg::REG_CAPACITY: dec.sel = ddc_pkg::SEL_CAPACITY;
      default:               dec.sel = ddc_pkg::SEL_NONE;
    endcase
  end

  assign full      = (cnt_r == ddc_pkg::CMDQ_CW'(ddc_pkg::CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = cmdq_r[rd_ptr_r];
  assign push_ok   = push && !full;
  assign pop_ok    = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == ddc_pkg::CMDQ_AW'(ddc_pkg::CMDQ_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == ddc_pkg::CMDQ_AW'(ddc_pkg::CMDQ_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      cmdq_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ===== src/ddc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddc_back
// Executes decoded commands against the controller registers and queues one
// result beat per command.
// ----------------------------------------------------------------------------
module ddc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ddc_pkg::CAP_W-1:0]     capacity,
  input  logic                          cmd_valid,
  input  ddc_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  output logic                          empty,
  input  logic                          pop,
  output ddc_pkg::res_t                 res
);

  logic                          ien_r, ien_nxt;
  logic                          wrt_r, wrt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          err_r, err_nxt;
  logic [ddc_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [ddc_pkg::CNT_W-1:0]     sector_r, sector_nxt;
  logic [ddc_pkg::DATA_W-1:0]    addr_r, addr_nxt;

  ddc_pkg::res_t                 resq_r [ddc_pkg::RESQ_DEPTH];
  logic [ddc_pkg::RESQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [ddc_pkg::RESQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [ddc_pkg::RESQ_CW-1:0]   cnt_r, cnt_nxt;

  ddc_pkg::res_t                 r;
  logic                          exec;
  logic                          out_pop;
  logic                          start_ok;
  logic [ddc_pkg::CNT_W:0]       range_end;
  logic [ddc_pkg::CNT_W-1:0]     cap_ext;
  logic [ddc_pkg::CNT_W-1:0]     count_dec;

  assign out_pop = pop && !empty;
  assign empty   = (cnt_r == '0);
  assign exec    = cmd_valid &&
                   ((cnt_r != ddc_pkg::RESQ_CW'(ddc_pkg::RESQ_DEPTH)) || out_pop);
  assign cmd_pop = exec;
  assign res     = resq_r[rd_ptr_r];

  // start is legal only when count is nonzero and the whole range lies on the disk
  assign cap_ext   = {1'b0, capacity};
  assign range_end = {1'b0, sector_r} + {1'b0, count_r};
  assign start_ok  = (cap_ext != '0) && (count_r != '0) && (sector_r < cap_ext) &&
                     (range_end <= {1'b0, cap_ext});
  assign count_dec = (count_r != '0) ? count_r - 1'b1 : count_r;

  always_comb begin
    ien_nxt    = ien_r;
    wrt_nxt    = wrt_r;
    busy_nxt   = busy_r;
    err_nxt    = err_r;
    count_nxt  = count_r;
    sector_nxt = sector_r;
    addr_nxt   = addr_r;
    r          = '0;
    if (exec) begin
      case (cmd.op)
        ddc_pkg::OP_READ: begin
          case (cmd.sel)
            ddc_pkg::SEL_CONTROL: begin
              r.read_data[ddc_pkg::CTL_IEN]  = ien_r;
              r.read_data[ddc_pkg::CTL_WRT]  = wrt_r;
              r.read_data[ddc_pkg::CTL_BUSY] = busy_r;
              r.read_data[ddc_pkg::CTL_ERR]  = err_r;
            end
            ddc_pkg::SEL_COUNT:    r.read_data = ddc_pkg::DATA_W'(count_r);
            ddc_pkg::SEL_SECTOR:   r.read_data = ddc_pkg::DATA_W'(sector_r);
            ddc_pkg::SEL_ADDR:     r.read_data = addr_r;
            ddc_pkg::SEL_CAPACITY: r.read_data = ddc_pkg::DATA_W'(capacity);
            default:               r.read_data = '0;
          endcase
        end
        ddc_pkg::OP_WRITE: begin
          if (!busy_r) begin
            case (cmd.sel)
              ddc_pkg::SEL_CONTROL: begin
                ien_nxt = cmd.data[ddc_pkg::CTL_IEN];
                wrt_nxt = cmd.data[ddc_pkg::CTL_WRT];
                if (cmd.data[ddc_pkg::CTL_STRT] && start_ok) begin
                  busy_nxt               = 1'b1;
                  err_nxt                = 1'b0;
                  r.sector_request       = 1'b1;
                  r.request_is_write     = cmd.data[ddc_pkg::CTL_WRT];
                  r.request_sector       = sector_r[ddc_pkg::SECT_W-1:0];
                  r.request_address      = addr_r;
                end
              end
              ddc_pkg::SEL_COUNT:  count_nxt  = cmd.data[ddc_pkg::CNT_W-1:0];
              ddc_pkg::SEL_SECTOR: sector_nxt = cmd.data[ddc_pkg::CNT_W-1:0];
              ddc_pkg::SEL_ADDR:   addr_nxt   = cmd.data;
              default: ;
            endcase
          end
        end
        ddc_pkg::OP_XFER_OK: begin
          if (busy_r) begin
            if (count_r != '0) begin
              addr_nxt   = addr_r + ddc_pkg::DATA_W'(ddc_pkg::SECTOR_BYTES);
              count_nxt  = count_dec;
              sector_nxt = sector_r + 1'b1;
            end
            if (count_dec != '0) begin
              r.sector_request   = 1'b1;
              r.request_is_write = wrt_r;
              r.request_sector   = sector_nxt[ddc_pkg::SECT_W-1:0];
              r.request_address  = addr_nxt;
            end else begin
              busy_nxt          = 1'b0;
              r.interrupt_pulse = ien_r;
            end
          end
        end
        ddc_pkg::OP_XFER_FAIL: begin
          if (busy_r) begin
            err_nxt           = 1'b1;
            busy_nxt          = 1'b0;
            r.interrupt_pulse = ien_r;
          end
        end
        default: ;
      endcase
      r.busy_res = busy_nxt;
      r.error    = err_nxt;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (exec) begin
      wr_ptr_nxt = (wr_ptr_r == ddc_pkg::RESQ_AW'(ddc_pkg::RESQ_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (out_pop) begin
      rd_ptr_nxt = (rd_ptr_r == ddc_pkg::RESQ_AW'(ddc_pkg::RESQ_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (exec && !out_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (out_pop && !exec) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ien_r    <= 1'b0;
      wrt_r    <= 1'b0;
      busy_r   <= 1'b0;
      err_r    <= 1'b0;
      count_r  <= '0;
      sector_r <= '0;
      addr_r   <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      ien_r    <= ien_nxt;
      wrt_r    <= wrt_nxt;
      busy_r   <= busy_nxt;
      err_r    <= err_nxt;
      count_r  <= count_nxt;
      sector_r <= sector_nxt;
      addr_r   <= addr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      resq_r[wr_ptr_r] <= r;
    end
  end

`ifndef SYNTHESIS
  // a running command always has sectors left
  a_busy_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (count_r != '0))
    else $error("busy with zero sector count");

  // a request leaves the controller busy
  a_req_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && r.sector_request) |=> busy_r)
    else $error("sector request without busy");

  // an interrupt only marks the end of a running command
  a_irq_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && r.interrupt_pulse) |-> (busy_r && ien_r) ##1 !busy_r)
    else $error("interrupt outside command end");

  // result queue never overflows
  a_resq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ddc_pkg::RESQ_CW'(ddc_pkg::RESQ_DEPTH))
    else $error("result queue overflow");
`endif

endmodule

// ===== src/dma_disk_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_disk_controller
// Sector DMA disk controller: register access and sector event handling.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (push/full): one beat is a bus register read, a register
//   write, or a sector done / sector failed report from the transfer engine.
//   Result queue (empty/pop): exactly one result beat per input beat, in
//   order: read data, any new sector request, interrupt pulse, BUSY and ERR.
//   APB port: capacity register (sectors on the disk) at byte address 0.
// Flow: an accepted beat is registered in the command queue, executed
//   from its head, and its result is registered in the result queue.
// Throughput: one beat per cycle while the result queue drains; the register
//   update in the execution stage is combinational. A two-entry command queue
//   and a two-entry result queue sit on either side of it.
// Reset: all registers and both queues clear; no clearing pass.
// Stall: when pop stays low the result queue fills, execution stops, then
//   the command queue fills and full rises. Nothing is dropped.
// ----------------------------------------------------------------------------
module dma_disk_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  // input queue
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    in_operation,
  input  logic [2:0]                    in_reg_index,
  input  logic [63:0]                   in_write_data,
  // result queue
  output logic                          empty,
  input  logic                          pop,
  output logic [63:0]                   out_read_data,
  output logic                          out_sector_request,
  output logic                          out_request_is_write,
  output logic [30:0]                   out_request_sector,
  output logic [63:0]                   out_request_address,
  output logic                          out_interrupt_pulse,
  output logic                          out_busy_res,
  output logic                          out_error,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ddc_pkg::APB_AW-1:0]    paddr,
  input  logic [ddc_pkg::APB_DW-1:0]    pwdata,
  output logic [ddc_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  logic [ddc_pkg::CAP_W-1:0]  capacity_r;
  logic                       cfg_wr;
  logic [0:0]                 cfg_word;
  logic                       cmd_valid;
  logic                       cmd_pop;
  ddc_pkg::cmd_t              cmd;
  ddc_pkg::res_t              res;

  assign pready   = 1'b1;
  assign cfg_word = paddr[2:2];
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (cfg_word == ddc_pkg::CFG_CAPACITY) ?
                    ddc_pkg::APB_DW'(capacity_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
    end else if (cfg_wr && (cfg_word == ddc_pkg::CFG_CAPACITY)) begin
      capacity_r <= pwdata[ddc_pkg::CAP_W-1:0];
    end
  end

  ddc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_operation  (in_operation),
    .in_reg_index  (in_reg_index),
    .in_write_data (in_write_data),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  ddc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .capacity  (capacity_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign out_read_data        = res.read_data;
  assign out_sector_request   = res.sector_request;
  assign out_request_is_write = res.request_is_write;
  assign out_request_sector   = res.request_sector;
  assign out_request_address  = res.request_address;
  assign out_interrupt_pulse  = res.interrupt_pulse;
  assign out_busy_res         = res.busy_res;
  assign out_error            = res.error;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sector DMA disk controller.
// A directed opening covers register truncation, ignored writes and events,
// address wrap and refused, completed and failed commands. Random phases then
// run well-formed commands mixed with noise beats, each phase under its own
// capacity setting. Every accepted beat is predicted in a scoreboard and each
// result beat is compared field by field. Random gaps are applied on both the
// input and the result side.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int SETTLE_CYCLES   = 4;
  localparam logic [ddc_pkg::APB_AW-1:0] CAP_ADDR = {ddc_pkg::CFG_CAPACITY, 2'b00};

  class disk_ctrl_scoreboard;
    logic [30:0]   capacity;
    logic          ien, wrt, busy, err;
    logic [31:0]   count, sector;
    logic [63:0]   addr;
    ddc_pkg::res_t expected_q[$];
    int            failures, beats, results;
    int            started, finished, failed, refused, irqs;

    function new();
      capacity = '0;
      ien = 1'b0;
      wrt = 1'b0;
      busy = 1'b0;
      err = 1'b0;
      count = '0;
      sector = '0;
      addr = '0;
    endfunction

    function void set_capacity(logic [30:0] value);
      capacity = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [63:0] register_value(logic [2:0] idx);
      logic [63:0] v;
      v = '0;
      case (idx)
        ddc_pkg::REG_CONTROL: begin
          v[ddc_pkg::CTL_IEN]  = ien;
          v[ddc_pkg::CTL_WRT]  = wrt;
          v[ddc_pkg::CTL_BUSY] = busy;
          v[ddc_pkg::CTL_ERR]  = err;
        end
        ddc_pkg::REG_COUNT:    v = {32'd0, count};
        ddc_pkg::REG_SECTOR:   v = {32'd0, sector};
        ddc_pkg::REG_DMA_ADDR: v = addr;
        ddc_pkg::REG_CAPACITY: v = {33'd0, capacity};
        default:               v = '0;
      endcase
      return v;
    endfunction

    function void issue(inout ddc_pkg::res_t want);
      want.sector_request   = 1'b1;
      want.request_is_write = wrt;
      want.request_sector   = sector[30:0];
      want.request_address  = addr;
    endfunction

    function void end_command(inout ddc_pkg::res_t want);
      busy = 1'b0;
      if (ien) begin
        want.interrupt_pulse = 1'b1;
        irqs++;
      end
    endfunction

    function void note_item(logic [1:0] op, logic [2:0] idx, logic [63:0] data);
      ddc_pkg::res_t want;
      logic [32:0]   range_end;
      want = '0;
      beats++;
      case (op)
        ddc_pkg::OP_READ: want.read_data = register_value(idx);
        ddc_pkg::OP_WRITE: if (!busy) begin
          case (idx)
            ddc_pkg::REG_CONTROL: begin
              ien = data[ddc_pkg::CTL_IEN];
              wrt = data[ddc_pkg::CTL_WRT];
              if (data[ddc_pkg::CTL_STRT]) begin
                range_end = {1'b0, sector} + {1'b0, count};
                if (capacity != 0 && count != 0 && sector < {1'b0, capacity} &&
                    range_end <= {2'b00, capacity}) begin
                  busy = 1'b1;
                  err  = 1'b0;
                  started++;
                  issue(want);
                end else begin
                  refused++;
                end
              end
            end
            ddc_pkg::REG_COUNT:    count = data[31:0];
            ddc_pkg::REG_SECTOR:   sector = data[31:0];
            ddc_pkg::REG_DMA_ADDR: addr = data;
            default: ;
          endcase
        end
        ddc_pkg::OP_XFER_OK: if (busy) begin
          if (count != 0) begin
            addr   = addr + 64'(ddc_pkg::SECTOR_BYTES);
            count  = count - 32'd1;
            sector = sector + 32'd1;
          end
          if (count != 0) begin
            issue(want);
          end else begin
            finished++;
            end_command(want);
          end
        end
        default: if (busy) begin
          err = 1'b1;
          failed++;
          end_command(want);
        end
      endcase
      want.busy_res = busy;
      want.error    = err;
      expected_q.push_back(want);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result %0d %s mismatch: expected %h, got %h",
                   $time, results, field, want, got);
      end
    endfunction

    function void check_result(ddc_pkg::res_t got);
      ddc_pkg::res_t want;
      results++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result beat %0d with nothing expected", $time, results);
        return;
      end
      want = expected_q.pop_front();
      compare("read_data", want.read_data, got.read_data);
      compare("sector_request", 64'(want.sector_request), 64'(got.sector_request));
      compare("request_is_write", 64'(want.request_is_write),
              64'(got.request_is_write));
      compare("request_sector", 64'(want.request_sector), 64'(got.request_sector));
      compare("request_address", want.request_address, got.request_address);
      compare("interrupt_pulse", 64'(want.interrupt_pulse), 64'(got.interrupt_pulse));
      compare("busy_res", 64'(want.busy_res), 64'(got.busy_res));
      compare("error", 64'(want.error), 64'(got.error));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_operation = '0;
  logic [2:0]  in_reg_index = '0;
  logic [63:0] in_write_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] out_read_data;
  logic        out_sector_request;
  logic        out_request_is_write;
  logic [30:0] out_request_sector;
  logic [63:0] out_request_address;
  logic        out_interrupt_pulse;
  logic        out_busy_res;
  logic        out_error;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ddc_pkg::APB_AW-1:0] paddr = '0;
  logic [ddc_pkg::APB_DW-1:0] pwdata = '0;
  logic [ddc_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  disk_ctrl_scoreboard sb = new();
  bit   steady = 1'b0;   // no gaps on either side
  int   pop_hold = 0;
  int   cycles = 0;
  ddc_pkg::res_t got;

  assign got = {out_read_data, out_sector_request, out_request_is_write, out_request_sector,
                out_request_address, out_interrupt_pulse, out_busy_res, out_error};

  dma_disk_controller uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .in_operation         (in_operation),
    .in_reg_index         (in_reg_index),
    .in_write_data        (in_write_data),
    .empty                (empty),
    .pop                  (pop),
    .out_read_data        (out_read_data),
    .out_sector_request   (out_sector_request),
    .out_request_is_write (out_request_is_write),
    .out_request_sector   (out_request_sector),
    .out_request_address  (out_request_address),
    .out_interrupt_pulse  (out_interrupt_pulse),
    .out_busy_res         (out_busy_res),
    .out_error            (out_error),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [63:0] ctl_word(bit ien, bit wrt, bit strt);
    logic [63:0] v;
    v = '0;
    v[ddc_pkg::CTL_IEN]  = ien;
    v[ddc_pkg::CTL_WRT]  = wrt;
    v[ddc_pkg::CTL_STRT] = strt;
    return v;
  endfunction

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, sb.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      sb.check_result(got);
  end

  // result side back-pressure: mostly short stalls, now and then a long one
  always @(posedge clk) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      if (!steady && $urandom_range(0, 99) < 30)
        pop_hold = pick_gap();
    end
  end

  // push stays high across back-to-back beats; lowered only for a gap or a settle
  task automatic send_item(logic [1:0] op, logic [2:0] idx, logic [63:0] data);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    in_operation  <= op;
    in_reg_index  <= idx;
    in_write_data <= data;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_item(op, idx, data);
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [30:0] value);
    logic top;
    top = 1'($urandom_range(0, 1));   // bit 31 is not part of the register
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {top, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_capacity(value);
  endtask

  initial begin : stimulus
    int          p, sent, cnt, pick;
    logic [30:0] cap_now;
    logic [31:0] sect;
    logic [63:0] addr_v, ctl_v;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // capacity is still zero: everything that would start is refused
    send_item(ddc_pkg::OP_WRITE, ddc_pkg::REG_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ddc_pkg::OP_READ, ddc_pkg::REG_COUNT, '0);
    send_item(ddc_pkg::OP_WRITE, ddc_pkg::REG_CONTROL, ctl_word(1, 1, 1));
    send_item(ddc_pkg::OP_READ, ddc_pkg::REG_CONTROL, '0);
    send_item(ddc_pkg::OP_XFER_OK, ddc_pkg::REG_CONTROL, '0);
    send_item(ddc_pkg::OP_XFER_FAIL, ddc_pkg::REG_CONTROL, '0);
    send_item(ddc_pkg::OP_WRITE, ddc_pkg::REG_CAPACITY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ddc_pkg::OP_READ, 3'd7, '0);
    settle();
    write_capacity(31'h7FFF_FFFF);

    // two sectors at the top of the disk, DMA address wraps past 2^64
    send_item(ddc_pkg::OP_WRITE, ddc_pkg::REG_SECTOR, 64'hFFFF_FFFF_7FFF_FFFD);
    send_item(ddc_pkg::OP_WRITE, ddc_pkg::REG_COUNT, 64'd2);
    send_item(ddc_pkg::OP_WRITE, ddc_pkg::REG_DMA_ADDR, 64'hFFFF_FFFF_FFFF_FF00);
    send_item(ddc_pkg::OP_WRITE, ddc_pkg::REG_CONTROL, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ddc_pkg::OP_WRITE, ddc_pkg::REG_COUNT, '0);
    send_item(ddc_pkg::OP_READ, ddc_pkg::REG_CONTROL, '0);
    send_item(ddc_pkg::OP_XFER_OK, ddc_pkg::REG_CONTROL, '0);
    send_item(ddc_pkg::OP_XFER_OK, ddc_pkg::REG_CONTROL, '0);
    // sector now equals capacity
    send_item(ddc_pkg::OP_WRITE, ddc_pkg::REG_COUNT, 64'd1);
    send_item(ddc_pkg::OP_WRITE, ddc_pkg::REG_CONTROL, ctl_word(0, 0, 1));
    send_item(ddc_pkg::OP_WRITE, ddc_pkg::REG_SECTOR, '0);
    send_item(ddc_pkg::OP_WRITE, ddc_pkg::REG_CONTROL, ctl_word(0, 0, 1));
    send_item(ddc_pkg::OP_XFER_FAIL, ddc_pkg::REG_CONTROL, '0);
    send_item(ddc_pkg::OP_READ, ddc_pkg::REG_CONTROL, '0);

    for (p = 0; p < PHASES; p++) begin
      settle();
      case (p % 5)
        0:       cap_now = 31'd1;
        1:       cap_now = 31'h7FFF_FFFF;
        2:       cap_now = (p == 2) ? 31'd0 : 31'($urandom_range(2, 64));
        3:       cap_now = 31'($urandom);
        default: cap_now = 31'($urandom_range(2, 4096));
      endcase
      write_capacity(cap_now);
      steady = (p % 4 == 2);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 70) begin
          // a noise beat may have left a long command running
          if (sb.busy) begin
            send_item(ddc_pkg::OP_XFER_FAIL, ddc_pkg::REG_CONTROL, {$urandom, $urandom});
            sent++;
          end
          pick = $urandom_range(0, 99);
          cnt = (pick < 70) ? $urandom_range(1, 4) :
                (pick < 95) ? $urandom_range(5, 16) : $urandom_range(17, 40);
          if (cap_now != 0 && cnt > cap_now)
            cnt = int'(cap_now);
          if (cap_now != 0 && $urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 3) == 0)
              sect = cap_now - cnt;
            else
              sect = $urandom_range(0, cap_now - cnt);
          end else if ($urandom_range(0, 1) == 1) begin
            sect = $urandom;
          end else begin
            sect = $urandom_range(0, 15);
            cnt = 0;
          end
          addr_v = ($urandom_range(0, 4) == 0) ?
                   64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 8191) : {$urandom, $urandom};
          ctl_v = {$urandom, $urandom};
          ctl_v[ddc_pkg::CTL_STRT] = ($urandom_range(0, 19) != 0);
          send_item(ddc_pkg::OP_WRITE, ddc_pkg::REG_COUNT, {$urandom, 32'(cnt)});
          send_item(ddc_pkg::OP_WRITE, ddc_pkg::REG_SECTOR, {$urandom, sect});
          send_item(ddc_pkg::OP_WRITE, ddc_pkg::REG_DMA_ADDR, addr_v);
          send_item(ddc_pkg::OP_WRITE, ddc_pkg::REG_CONTROL, ctl_v);
          sent += 4;
          while (sb.busy) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
              send_item(ddc_pkg::OP_XFER_OK, 3'($urandom_range(0, 7)),
                        {$urandom, $urandom});
            else if (pick < 75)
              send_item(ddc_pkg::OP_XFER_FAIL, 3'($urandom_range(0, 7)),
                        {$urandom, $urandom});
            else if (pick < 90)
              send_item(ddc_pkg::OP_READ, 3'($urandom_range(0, 7)),
                        {$urandom, $urandom});
            else
              send_item(ddc_pkg::OP_WRITE, 3'($urandom_range(0, 7)),
                        {$urandom, $urandom});
            sent++;
          end
        end else begin
          addr_v = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} :
                   64'($urandom_range(0, 15));
          send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), addr_v);
          sent++;
        end
      end
      if (sb.busy)
        send_item(ddc_pkg::OP_XFER_FAIL, ddc_pkg::REG_CONTROL, '0);
    end

    settle();
    $display("%0d beats checked: %0d commands started, %0d ran to the end, %0d failed",
             sb.results, sb.started, sb.finished, sb.failed);
    $display("%0d starts refused, %0d interrupts, %0d capacity settings, %0d failures",
             sb.refused, sb.irqs, PHASES + 1, sb.failures);
    if (sb.failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
